@@ rtl/box_move_with_collision_check_core_assert.svh @@
// assertion helpers for the checker file
// both expect i_clk and i_rst_n in the scope where they are used
`ifndef BOX_MOVE_WITH_COLLISION_CHECK_CORE_ASSERT_SVH
`define BOX_MOVE_WITH_COLLISION_CHECK_CORE_ASSERT_SVH

// same-cycle implication
`define BMCC_ASSERT_IMP(lbl, ante, cons, msg) \
lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BMCC_ASSERT_NXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/bmcc_pkg.sv @@
`default_nettype none

package bmcc_pkg;

    // request codes
    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_MOVE = 1'b1;

    // result status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_BLOCKED = 2'd1;
    localparam logic [1:0] ST_FAIL    = 2'd2;

    localparam logic [3:0]  SHAPE_MAX  = 4'd10;
    localparam logic [15:0] ISO_X_BASE = 16'd96;
    localparam logic [15:0] ISO_Y_BASE = 16'd128;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  obj_index;
        logic [3:0]  shape_sel;
        logic signed [7:0] delta_x;
        logic signed [7:0] delta_y;
        logic signed [7:0] delta_z;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [15:0] centre_x;
        logic signed [15:0] centre_y;
        logic signed [15:0] centre_z;
        logic signed [15:0] screen_x;
        logic signed [15:0] screen_y;
    } t_rsp;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_vec3;

    typedef struct packed {
        t_vec3      centre;
        logic [3:0] shape;
        t_vec3      low;
        t_vec3      high;
    } t_box_entry;

    function automatic logic [3:0] shape_sat(input logic [3:0] s);
        return (s > SHAPE_MAX) ? SHAPE_MAX : s;
    endfunction

    // half-extents per shape, all small positive values
    function automatic t_vec3 half_ext(input logic [3:0] s);
        t_vec3 v;
        v = '0;
        case (s)
            4'd0:    begin v.x = 16'sd4; v.y = 16'sd4; v.z = 16'sd4; end
            4'd1:    begin v.x = 16'sd8; v.y = 16'sd8; v.z = 16'sd8; end
            4'd2:    begin v.x = 16'sd4; v.y = 16'sd4; v.z = 16'sd8; end
            4'd3:    begin v.x = 16'sd8; v.y = 16'sd4; v.z = 16'sd4; end
            4'd4:    begin v.x = 16'sd4; v.y = 16'sd8; v.z = 16'sd4; end
            4'd5:    begin v.x = 16'sd8; v.y = 16'sd4; v.z = 16'sd8; end
            4'd6:    begin v.x = 16'sd4; v.y = 16'sd8; v.z = 16'sd8; end
            4'd7:    begin v.x = 16'sd8; v.y = 16'sd2; v.z = 16'sd8; end
            4'd8:    begin v.x = 16'sd2; v.y = 16'sd8; v.z = 16'sd8; end
            4'd9:    begin v.x = 16'sd2; v.y = 16'sd2; v.z = 16'sd2; end
            default: begin v.x = 16'sd1; v.y = 16'sd1; v.z = 16'sd1; end
        endcase
        return v;
    endfunction

    // sprite offset of the shape, x then y
    function automatic logic [9:0] scr_off(input logic [3:0] s);
        logic [9:0] v;
        case (s)
            4'd0:    v = {5'd8,  5'd8};
            4'd1:    v = {5'd16, 5'd16};
            4'd2:    v = {5'd12, 5'd8};
            4'd3:    v = {5'd10, 5'd12};
            4'd4:    v = {5'd10, 5'd12};
            4'd5:    v = {5'd14, 5'd12};
            4'd6:    v = {5'd14, 5'd12};
            4'd7:    v = {5'd13, 5'd10};
            4'd8:    v = {5'd13, 5'd10};
            4'd9:    v = {5'd4,  5'd4};
            default: v = {5'd0,  5'd0};
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/bmcc_req_if.sv @@
`default_nettype none

interface bmcc_req_if;
    import bmcc_pkg::*;

    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/bmcc_rsp_if.sv @@
`default_nettype none

interface bmcc_rsp_if;
    import bmcc_pkg::*;

    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/bmcc_ram.sv @@
`default_nettype none

module bmcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ rtl/box_move_with_collision_check_core.sv @@
// box table with collision-checked moves
// i_req (sink): one request per transfer, add (new box at origin with a shape)
//   or move (shift a stored box by a signed delta)
// o_rsp (source): exactly one result per request, in request order
// the box table lives in one single-port-read ram with a registered read;
//   a move reads its own entry, then reads the stored boxes one per cycle
//   and tests strict overlap on all three axes against the candidate bounds;
//   a hit ends the scan early
// one request is worked at a time; i_req.ready is high while the core is idle
// the result sits in an output register; a new request is taken while it waits,
//   and a finished result holds in the core until the register frees up
// reset clears the box count and the handshake state; ram contents are not
//   cleared, since only entries below the count are ever used
// no clearing pass is needed after reset
`default_nettype none

module box_move_with_collision_check_core #(
    parameter int MAX_BOXES = 256
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    bmcc_req_if.sink     i_req,
    bmcc_rsp_if.source   o_rsp
);
    import bmcc_pkg::*;

    localparam int CNT_W = $clog2(MAX_BOXES + 1);
    localparam int AW    = $clog2(MAX_BOXES);
    localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    // control registers
    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_out_valid, n_out_valid;

    // payload registers
    logic [AW-1:0] r_addr, n_addr;        // ram address whose data is on rd
    t_req          r_req, n_req;          // request being worked
    t_vec3         r_base, n_base;        // centre of the moved box before the move
    logic [3:0]    r_shape, n_shape;
    t_vec3         r_cand, n_cand;        // candidate centre
    t_vec3         r_lo, n_lo;
    t_vec3         r_hi, n_hi;
    t_rsp          r_res, n_res;          // finished result waiting for the output
    t_rsp          r_out, n_out;

    // ram port
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    t_box_entry    ram_wdata;
    t_box_entry    rd;

    bmcc_ram #(
        .WIDTH ($bits(t_box_entry)),
        .DEPTH (MAX_BOXES)
    ) u_box_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd)
    );

    // index against the fill count
    logic [CMP_W-1:0] idx_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic [AW-1:0]    idx_addr;
    logic             cnt_full;
    logic [CNT_W-1:0] cnt_last;

    assign idx_ext  = CMP_W'(r_req.obj_index);
    assign cnt_ext  = CMP_W'(r_count);
    assign idx_addr = idx_ext[AW-1:0];
    assign cnt_full = (r_count == CNT_W'(MAX_BOXES));
    assign cnt_last = r_count - CNT_W'(1);

    // candidate bounds from the entry read for the moved box
    t_vec3 he;
    t_vec3 cand;
    t_vec3 lo;
    t_vec3 hi;

    assign he     = half_ext(rd.shape);
    assign cand.x = rd.centre.x + {{8{r_req.delta_x[7]}}, r_req.delta_x};
    assign cand.y = rd.centre.y + {{8{r_req.delta_y[7]}}, r_req.delta_y};
    assign cand.z = rd.centre.z + {{8{r_req.delta_z[7]}}, r_req.delta_z};
    assign lo.x   = cand.x - he.x;
    assign lo.y   = cand.y - he.y;
    assign lo.z   = cand.z - he.z;
    assign hi.x   = cand.x + he.x;
    assign hi.y   = cand.y + he.y;
    assign hi.z   = cand.z + he.z;

    // strict overlap against the scanned entry, the moved box itself excluded
    logic ov_x, ov_y, ov_z, hit, scan_last;

    assign ov_x      = (r_lo.x < rd.high.x) && (r_hi.x > rd.low.x);
    assign ov_y      = (r_lo.y < rd.high.y) && (r_hi.y > rd.low.y);
    assign ov_z      = (r_lo.z < rd.high.z) && (r_hi.z > rd.low.z);
    assign hit       = (r_addr != idx_addr) && ov_x && ov_y && ov_z;
    assign scan_last = (CNT_W'(r_addr) == cnt_last);

    // isometric screen position, wraps at 16 bits
    logic [16:0] sum_xy;
    logic [9:0]  off;
    logic [15:0] scr_x, scr_y;

    assign sum_xy = {r_cand.x[15], r_cand.x} + {r_cand.y[15], r_cand.y};
    assign off    = scr_off(r_shape);
    // bits 16:1 of the sum are the floor of half of it
    assign scr_x  = ISO_X_BASE + sum_xy[16:1] - r_cand.z - {11'd0, off[9:5]};
    assign scr_y  = ISO_Y_BASE + r_cand.x - r_cand.y - {11'd0, off[4:0]};

    assign i_req.ready   = (r_state == S_IDLE);
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_addr      = r_addr;
        n_req       = r_req;
        n_base      = r_base;
        n_shape     = r_shape;
        n_cand      = r_cand;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_res       = r_res;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = idx_addr;
        ram_wdata   = '0;
        ram_raddr   = r_addr + AW'(1);

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_req   = i_req.payload;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_res     = '0;
                ram_raddr = idx_addr;
                if (r_req.req_type == REQ_ADD) begin
                    if (cnt_full) begin
                        n_res.status = ST_FAIL;
                    end else begin
                        // new box at the origin with zero bounds
                        ram_we          = 1'b1;
                        ram_waddr       = r_count[AW-1:0];
                        ram_wdata.shape = shape_sat(r_req.shape_sel);
                        n_count         = r_count + CNT_W'(1);
                        n_res.status    = ST_DONE;
                    end
                    n_state = S_DONE;
                end else if (idx_ext >= cnt_ext) begin
                    n_res.status = ST_FAIL;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                // own entry is on rd; start the scan at entry zero
                ram_raddr = '0;
                n_addr    = '0;
                n_base    = rd.centre;
                n_shape   = rd.shape;
                n_cand    = cand;
                n_lo      = lo;
                n_hi      = hi;
                n_state   = S_SCAN;
            end
            S_SCAN: begin
                if (hit) begin
                    n_res          = '0;
                    n_res.status   = ST_BLOCKED;
                    n_res.centre_x = r_base.x;
                    n_res.centre_y = r_base.y;
                    n_res.centre_z = r_base.z;
                    n_state        = S_DONE;
                end else if (scan_last) begin
                    // clear of every box: commit the move
                    ram_we           = 1'b1;
                    ram_waddr        = idx_addr;
                    ram_wdata.centre = r_cand;
                    ram_wdata.shape  = r_shape;
                    ram_wdata.low    = r_lo;
                    ram_wdata.high   = r_hi;
                    n_res.status     = ST_DONE;
                    n_res.centre_x   = r_cand.x;
                    n_res.centre_y   = r_cand.y;
                    n_res.centre_z   = r_cand.z;
                    n_res.screen_x   = scr_x;
                    n_res.screen_y   = scr_y;
                    n_state          = S_DONE;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr  <= n_addr;
        r_req   <= n_req;
        r_base  <= n_base;
        r_shape <= n_shape;
        r_cand  <= n_cand;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_res   <= n_res;
        r_out   <= n_out;
    end

endmodule

`default_nettype wire

@@ rtl/bmcc_checker.sv @@
`default_nettype none
`include "box_move_with_collision_check_core_assert.svh"

module bmcc_checker (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            i_req_valid,
    input wire logic            i_req_ready,
    input wire logic            i_rsp_valid,
    input wire logic            i_rsp_ready,
    input wire bmcc_pkg::t_rsp  i_rsp
);
    import bmcc_pkg::*;

    logic rsp_stall;
    logic req_xfer;
    logic status_ok;
    logic screen_zero;

    assign rsp_stall   = i_rsp_valid && !i_rsp_ready;
    assign req_xfer    = i_req_valid && i_req_ready;
    assign status_ok   = (i_rsp.status == ST_DONE) || (i_rsp.status == ST_BLOCKED) ||
                         (i_rsp.status == ST_FAIL);
    assign screen_zero = (i_rsp.screen_x == 16'sd0) && (i_rsp.screen_y == 16'sd0);

    // result stays offered until taken
    `BMCC_ASSERT_NXT(a_rsp_hold, rsp_stall, i_rsp_valid, "result dropped while stalled")

    `BMCC_ASSERT_NXT(a_rsp_stable, rsp_stall, $stable(i_rsp), "result changed while stalled")

    `BMCC_ASSERT_IMP(a_status_code, i_rsp_valid, status_ok, "undefined status code")

    // only a completed request reports a screen position
    `BMCC_ASSERT_IMP(a_screen_zero, i_rsp_valid && (i_rsp.status != ST_DONE), screen_zero, "screen set on refused request")

    // one request in work at a time
    `BMCC_ASSERT_NXT(a_one_at_a_time, req_xfer, !i_req_ready, "request taken while busy")

endmodule

bind box_move_with_collision_check_core bmcc_checker u_bmcc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp       (o_rsp.payload)
);

`default_nettype wire

@@ dv/box_move_with_collision_check_core_tb.sv @@
`timescale 1ns / 100ps

module box_move_with_collision_check_core_tb;
    import bmcc_pkg::*;

    localparam int TABLE_DEPTH  = 256;
    localparam int TOTAL_ITEMS  = 1100;
    localparam int FILL_AT      = 700;     // item count at which the table gets filled up
    localparam int DRIFT_ITEMS  = 300;     // long drift, enough to wrap a coordinate
    localparam int DRAIN_CYCLES = 300;     // a full scan of the table plus margin
    localparam int CYCLE_LIMIT  = 1500000;
    localparam int REPORT_MAX   = 10;

    // box table model: holds its own copy of the table and the results it predicts
    class box_table_model;
        int unsigned        n_boxes;
        logic signed [15:0] ctr   [TABLE_DEPTH][3];
        logic [3:0]         shp   [TABLE_DEPTH];
        logic signed [15:0] lo_c  [TABLE_DEPTH][3];
        logic signed [15:0] hi_c  [TABLE_DEPTH][3];
        t_rsp               pending_results[$];
        int                 n_checked;
        int                 n_errors;
        int                 n_reported;
        int                 n_added;
        int                 n_moved;
        int                 n_blocked;
        int                 n_rejected;

        function new();
            n_boxes = 0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                shp[i] = '0;
                for (int a = 0; a < 3; a++) begin
                    ctr[i][a]  = '0;
                    lo_c[i][a] = '0;
                    hi_c[i][a] = '0;
                end
            end
            n_checked  = 0;
            n_errors   = 0;
            n_reported = 0;
            n_added    = 0;
            n_moved    = 0;
            n_blocked  = 0;
            n_rejected = 0;
        endfunction

        function int wrap16(int v);
            logic signed [15:0] t;
            t = v[15:0];
            return int'(t);
        endfunction

        // works out the result of one request and updates the table
        function t_rsp apply_request(t_req r);
            t_rsp res;
            int   idx, s, ox, oy;
            int   d[3], h[3], cand[3], lo[3], hi[3];
            bit   hit, all_ax;
            res = '0;
            d[0] = int'(r.delta_x);
            d[1] = int'(r.delta_y);
            d[2] = int'(r.delta_z);
            if (r.req_type == REQ_ADD) begin
                if (n_boxes >= TABLE_DEPTH) begin
                    res.status = ST_FAIL;
                    n_rejected++;
                    return res;
                end
                s = (r.shape_sel > SHAPE_MAX) ? int'(SHAPE_MAX) : int'(r.shape_sel);
                for (int a = 0; a < 3; a++) begin
                    ctr[n_boxes][a]  = '0;
                    lo_c[n_boxes][a] = '0;
                    hi_c[n_boxes][a] = '0;
                end
                shp[n_boxes] = s[3:0];
                n_boxes++;
                res.status = ST_DONE;
                n_added++;
                return res;
            end
            idx = int'(r.obj_index);
            if (idx >= n_boxes) begin
                res.status = ST_FAIL;
                n_rejected++;
                return res;
            end
            s = int'(shp[idx]);
            case (s)
                0:       begin h = '{4, 4, 4}; ox = 8;  oy = 8;  end
                1:       begin h = '{8, 8, 8}; ox = 16; oy = 16; end
                2:       begin h = '{4, 4, 8}; ox = 12; oy = 8;  end
                3:       begin h = '{8, 4, 4}; ox = 10; oy = 12; end
                4:       begin h = '{4, 8, 4}; ox = 10; oy = 12; end
                5:       begin h = '{8, 4, 8}; ox = 14; oy = 12; end
                6:       begin h = '{4, 8, 8}; ox = 14; oy = 12; end
                7:       begin h = '{8, 2, 8}; ox = 13; oy = 10; end
                8:       begin h = '{2, 8, 8}; ox = 13; oy = 10; end
                9:       begin h = '{2, 2, 2}; ox = 4;  oy = 4;  end
                default: begin h = '{1, 1, 1}; ox = 0;  oy = 0;  end
            endcase
            for (int a = 0; a < 3; a++) begin
                cand[a] = wrap16(int'(ctr[idx][a]) + d[a]);
                lo[a]   = wrap16(cand[a] - h[a]);
                hi[a]   = wrap16(cand[a] + h[a]);
            end
            // strict overlap on every axis against every other stored box
            hit = 1'b0;
            for (int o = 0; o < n_boxes && !hit; o++) begin
                if (o != idx) begin
                    all_ax = 1'b1;
                    for (int a = 0; a < 3; a++) begin
                        if (!(lo[a] < int'(hi_c[o][a]) && hi[a] > int'(lo_c[o][a])))
                            all_ax = 1'b0;
                    end
                    hit = all_ax;
                end
            end
            if (hit) begin
                res.status   = ST_BLOCKED;
                res.centre_x = ctr[idx][0];
                res.centre_y = ctr[idx][1];
                res.centre_z = ctr[idx][2];
                n_blocked++;
                return res;
            end
            for (int a = 0; a < 3; a++) begin
                ctr[idx][a]  = cand[a][15:0];
                lo_c[idx][a] = lo[a][15:0];
                hi_c[idx][a] = hi[a][15:0];
            end
            res.status   = ST_DONE;
            res.centre_x = cand[0][15:0];
            res.centre_y = cand[1][15:0];
            res.centre_z = cand[2][15:0];
            res.screen_x = 16'(int'(ISO_X_BASE) + ((cand[0] + cand[1]) >>> 1) - cand[2] - ox);
            res.screen_y = 16'(int'(ISO_Y_BASE) + cand[0] - cand[1] - oy);
            n_moved++;
            return res;
        endfunction

        function void note_request(t_req r);
            pending_results.push_back(apply_request(r));
        endfunction

        function void check_result(t_rsp got);
            t_rsp want;
            if (pending_results.size() == 0) begin
                n_errors++;
                if (n_reported < REPORT_MAX) begin
                    n_reported++;
                    $display("unexpected result, none outstanding: status %0d centre (%0d,%0d,%0d)",
                             got.status, got.centre_x, got.centre_y, got.centre_z);
                end
                return;
            end
            want = pending_results.pop_front();
            n_checked++;
            if (got.status !== want.status || got.centre_x !== want.centre_x ||
                got.centre_y !== want.centre_y || got.centre_z !== want.centre_z ||
                got.screen_x !== want.screen_x || got.screen_y !== want.screen_y) begin
                n_errors++;
                if (n_reported < REPORT_MAX) begin
                    n_reported++;
                    $display("result %0d mismatch at %0t:", n_checked, $realtime);
                    $display("  status exp %0d got %0d", want.status, got.status);
                    $display("  centre exp (%0d,%0d,%0d) got (%0d,%0d,%0d)",
                             want.centre_x, want.centre_y, want.centre_z,
                             got.centre_x, got.centre_y, got.centre_z);
                    $display("  screen exp (%0d,%0d) got (%0d,%0d)",
                             want.screen_x, want.screen_y, got.screen_x, got.screen_y);
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    bmcc_req_if req_bus ();
    bmcc_rsp_if rsp_bus ();

    box_move_with_collision_check_core #(
        .MAX_BOXES(TABLE_DEPTH)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_bus),
        .o_rsp  (rsp_bus)
    );

    box_table_model box_table;
    int             n_sent = 0;
    int             burst_left = 0;
    int unsigned    cycle_count = 0;

    // 12 ns clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // guard against a hung handshake
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still outstanding",
                     cycle_count, box_table.pending_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // every accepted result transfer is checked against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready)
            box_table.check_result(rsp_bus.payload);
    end

    // result side stalls: always ready, a rotating bit pattern, or sparse/random ready
    initial begin
        int          mode;
        int          span;
        logic [15:0] pattern;
        rsp_bus.ready = 1'b0;
        forever begin
            mode    = $urandom_range(0, 3);
            span    = $urandom_range(20, 200);
            pattern = 16'($urandom);
            for (int k = 0; k < span; k++) begin
                @(negedge i_clk);
                case (mode)
                    0:       rsp_bus.ready = 1'b1;
                    1:       rsp_bus.ready = pattern[k % 16];
                    2:       rsp_bus.ready = ($urandom_range(0, 7) == 0);
                    default: rsp_bus.ready = 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    // one request transfer; the sender runs in bursts, mostly with idle gaps between them
    task automatic send_request(input t_req r);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            repeat (gap) begin
                @(negedge i_clk);
                req_bus.valid = 1'b0;
            end
        end
        burst_left--;
        @(negedge i_clk);
        req_bus.valid   = 1'b1;
        req_bus.payload = r;
        do @(posedge i_clk); while (!req_bus.ready);
        box_table.note_request(r);
        n_sent++;
    endtask

    // fields that the request type ignores still get random values
    function automatic t_req make_add(input logic [3:0] s);
        t_req r;
        r.req_type  = REQ_ADD;
        r.obj_index = 8'($urandom);
        r.shape_sel = s;
        r.delta_x   = 8'($urandom);
        r.delta_y   = 8'($urandom);
        r.delta_z   = 8'($urandom);
        return r;
    endfunction

    function automatic t_req make_move(input int idx, input int dx, input int dy, input int dz);
        t_req r;
        r.req_type  = REQ_MOVE;
        r.obj_index = idx[7:0];
        r.shape_sel = 4'($urandom);
        r.delta_x   = dx[7:0];
        r.delta_y   = dy[7:0];
        r.delta_z   = dz[7:0];
        return r;
    endfunction

    function automatic int big_step(input bit neg);
        return neg ? -int'($urandom_range(100, 128)) : int'($urandom_range(100, 127));
    endfunction

    function automatic int clamp8(input int v);
        return (v > 127) ? 127 : ((v < -128) ? -128 : v);
    endfunction

    task automatic run_directed();
        send_request(make_move(0, 0, 0, 0));            // move with an empty table
        send_request(make_add(4'd0));
        send_request(make_add(SHAPE_MAX));
        send_request(make_add(4'd15));                  // shape index saturates
        send_request(make_add(4'd11));
        send_request(make_move(0, 0, 0, 0));            // origin boxes block it
        send_request(make_move(1, 127, 127, 127));
        send_request(make_move(0, -128, -128, -128));
        send_request(make_move(2, 127, -128, 127));
        send_request(make_move(3, -1, -1, -1));
        send_request(make_move(3, 126, 126, 126));      // faces touch box 1, no overlap
        send_request(make_move(3, 1, 1, 1));            // now it overlaps box 1
        send_request(make_move(4, 5, 5, 5));            // one past the last box
        send_request(make_move(255, -7, 3, 0));         // far past the last box
        send_request(make_add(4'd7));
        send_request(make_move(4, 0, 0, 100));
        send_request(make_move(4, 0, -128, 127));
    endtask

    task automatic run_random();
        int kind, len, w, t;
        int dl[3];
        bit sg[3];
        bit table_filled;
        table_filled = 1'b0;

        // one box drifts far in one direction per axis, so centres and screen values wrap
        w = $urandom_range(0, box_table.n_boxes - 1);
        for (int a = 0; a < 3; a++) sg[a] = 1'($urandom_range(0, 1));
        for (int k = 0; k < DRIFT_ITEMS; k++) begin
            for (int a = 0; a < 3; a++) dl[a] = big_step(sg[a]);
            send_request(make_move(w, dl[0], dl[1], dl[2]));
        end

        while (n_sent < TOTAL_ITEMS) begin
            if (!table_filled && n_sent >= FILL_AT) begin
                // fill the last free slots, then a few adds that must be refused
                len = TABLE_DEPTH - box_table.n_boxes + 3;
                repeat (len) send_request(make_add(4'($urandom_range(0, 15))));
                table_filled = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 25) begin
                // a run of adds, mostly legal shapes
                len = $urandom_range(2, 10);
                repeat (len) send_request(make_add(4'($urandom_range(0, 15))));
            end else if (kind < 55 || box_table.n_boxes < 2) begin
                // small moves around the current spot, often blocked near the origin
                len = $urandom_range(4, 20);
                repeat (len) begin
                    w = $urandom_range(0, box_table.n_boxes - 1);
                    send_request(make_move(w, int'($urandom_range(0, 48)) - 24,
                                           int'($urandom_range(0, 48)) - 24,
                                           int'($urandom_range(0, 48)) - 24));
                end
            end else if (kind < 75) begin
                // steer one box onto another until the overlap test stops it
                w = $urandom_range(0, box_table.n_boxes - 1);
                t = (w + $urandom_range(1, box_table.n_boxes - 1)) % box_table.n_boxes;
                len = $urandom_range(3, 10);
                repeat (len) begin
                    for (int a = 0; a < 3; a++)
                        dl[a] = clamp8(box_table.wrap16(int'(box_table.ctr[t][a]) -
                                                        int'(box_table.ctr[w][a])) +
                                       int'($urandom_range(0, 24)) - 12);
                    send_request(make_move(w, dl[0], dl[1], dl[2]));
                end
            end else if (kind < 85) begin
                // shorter drift of a random box
                w = $urandom_range(0, box_table.n_boxes - 1);
                for (int a = 0; a < 3; a++) sg[a] = 1'($urandom_range(0, 1));
                len = $urandom_range(10, 40);
                repeat (len) begin
                    for (int a = 0; a < 3; a++) dl[a] = big_step(sg[a]);
                    send_request(make_move(w, dl[0], dl[1], dl[2]));
                end
            end else begin
                // noise: every field random, including unused indexes
                len = $urandom_range(3, 10);
                repeat (len) begin
                    if ($urandom_range(0, 1) == 0)
                        send_request(make_add(4'($urandom)));
                    else
                        send_request(make_move($urandom_range(0, 255), int'($urandom_range(0, 255)),
                                               int'($urandom_range(0, 255)),
                                               int'($urandom_range(0, 255))));
                end
            end
        end
    endtask

    initial begin
        box_table       = new();
        i_rst_n         = 1'b0;
        req_bus.valid   = 1'b0;
        req_bus.payload = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        run_directed();
        run_random();
        @(negedge i_clk);
        req_bus.valid = 1'b0;

        // drain outstanding results, then give the core time to show any stray transfer
        while (box_table.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d requests: %0d adds, %0d moves done, %0d blocked, %0d refused",
                 n_sent, box_table.n_added, box_table.n_moved, box_table.n_blocked,
                 box_table.n_rejected);
        $display("%0d results checked, %0d errors, %0d boxes in table at the end",
                 box_table.n_checked, box_table.n_errors, box_table.n_boxes);
        if (box_table.n_errors == 0 && box_table.pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
